// File: rtl/core/ild_pkg.sv
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and constants for the indexed list block: field widths,
// operation and status codes, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ild_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  localparam int IN_W  = 48;  // op + pos + val, padded to bytes
  localparam int OUT_W = 48;  // value + count + status, padded to bytes

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_DELETE = 3'd3,
    OP_INSERT = 3'd4
  } op_e;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_DONE
  } ctrl_state_e;

  // write address source
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_IDX
  } wa_sel_e;

  // read address source
  typedef enum logic [1:0] {
    RA_POS,
    RA_IDX_UP,
    RA_IDX_DN
  } ra_sel_e;

  typedef struct packed {
    logic    load;        // capture input beat
    logic    st_load;     // hold the item's status before the count moves
    logic    wr_en;
    wa_sel_e wr_sel;
    logic    wd_shift;    // write data from read register, else input value
    logic    rd_en;
    ra_sel_e rd_sel;
    logic    idx_ld_pos;
    logic    idx_ld_cnt;
    logic    idx_inc;
    logic    idx_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } ild_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;        // no range or full error on latched item
    logic            del_more;  // idx + 1 < count
    logic            ins_more;  // idx > pos
    logic            out_free;  // result register can take a new beat
  } ild_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ild_ctrl.sv
// ----------------------------------------------------------------------------
// ild_ctrl
// Sequencer for the indexed list: decodes the latched operation and steps
// the datapath through memory accesses and element shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire ild_pkg::ild_sts_t sts_i,
  output ild_pkg::ild_cmd_t  cmd_o
);
  import ild_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.wr_sel = WA_COUNT;
    cmd_o.rd_sel = RA_POS;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d       = S_DONE;
        cmd_o.st_load = 1'b1;
        if (sts_i.ok) begin
          case (sts_i.op)
            OP_APPEND: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WA_COUNT;
              cmd_o.cnt_inc = 1'b1;
            end
            OP_READ: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_POS;
            end
            OP_WRITE: begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WA_POS;
            end
            OP_DELETE: begin
              cmd_o.idx_ld_pos = 1'b1;
              state_d          = S_DEL_RD;
            end
            OP_INSERT: begin
              cmd_o.idx_ld_cnt = 1'b1;
              state_d          = S_INS_RD;
            end
            default: ;  // unused codes: report and change nothing
          endcase
        end
      end
      S_DEL_RD: begin
        if (sts_i.del_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX_UP;
          state_d      = S_DEL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WA_IDX;
        cmd_o.wd_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_DEL_RD;
      end
      S_INS_RD: begin
        if (sts_i.ins_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_IDX_DN;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WA_POS;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WA_IDX;
        cmd_o.wd_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_INS_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ild_dpath.sv
// ----------------------------------------------------------------------------
// ild_dpath
// List storage, element count, shift index, error checks and the result
// register of the indexed list.
// ----------------------------------------------------------------------------
`default_nettype none

module ild_dpath #(
  parameter int DEPTH = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire ild_pkg::ild_cmd_t      cmd_i,
  output ild_pkg::ild_sts_t           sts_o,
  input  wire [ild_pkg::OP_W-1:0]     op_i,
  input  wire [ild_pkg::POS_W-1:0]    pos_i,
  input  wire signed [ild_pkg::VAL_W-1:0] val_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic signed [ild_pkg::VAL_W-1:0] rd_val_o,
  output logic [ild_pkg::CNT_W-1:0]   cnt_o,
  output logic [ild_pkg::ST_W-1:0]    st_o
);
  import ild_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [OP_W-1:0]         op_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic [CW-1:0]           count_q, count_d;
  logic [XW-1:0]           idx_q, idx_d;
  logic [ST_W-1:0]         st_hold_q;
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] rd_val_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [ST_W-1:0]         st_q;

  logic [XW-1:0]    pos_x, cnt_x, idx_up, idx_dn;
  logic             full;
  logic [ST_W-1:0]  st;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic signed [VAL_W-1:0] wr_data;

  assign pos_x  = XW'(pos_q);
  assign cnt_x  = XW'(count_q);
  assign idx_up = idx_q + XW'(1);
  assign idx_dn = idx_q - XW'(1);
  assign full   = (count_q == CW'(DEPTH));

  // error checks on the latched item; insert tests range before full
  always_comb begin
    st = ST_OK;
    case (op_q)
      OP_APPEND: st = full ? ST_FULL : ST_OK;
      OP_READ, OP_WRITE, OP_DELETE: st = (pos_x >= cnt_x) ? ST_RANGE : ST_OK;
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign sts_o.op       = op_q;
  assign sts_o.ok       = (st == ST_OK);
  assign sts_o.del_more = ({1'b0, idx_up} < {1'b0, cnt_x}) && (idx_q != '1);
  assign sts_o.ins_more = (idx_q > pos_x);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.wr_sel)
      WA_COUNT: wr_addr = cnt_x[AW-1:0];
      WA_POS:   wr_addr = pos_x[AW-1:0];
      WA_IDX:   wr_addr = idx_q[AW-1:0];
      default:  wr_addr = idx_q[AW-1:0];
    endcase
    case (cmd_i.rd_sel)
      RA_POS:    rd_addr = pos_x[AW-1:0];
      RA_IDX_UP: rd_addr = idx_up[AW-1:0];
      RA_IDX_DN: rd_addr = idx_dn[AW-1:0];
      default:   rd_addr = pos_x[AW-1:0];
    endcase
  end

  assign wr_data = cmd_i.wd_shift ? rdata_q : val_q;

  // storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // input and result payload; status is held from the check cycle since
  // the count has already moved by the time the result is loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      pos_q <= pos_i;
      val_q <= val_i;
    end
    if (cmd_i.st_load) begin
      st_hold_q <= st;
    end
    if (cmd_i.out_load) begin
      rd_val_q <= ((op_q == OP_READ) && (st_hold_q == ST_OK)) ? rdata_q : '0;
      cnt_q    <= CNT_W'(count_q);
      st_q     <= st_hold_q;
    end
    idx_q <= idx_d;
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_ld_pos) begin
      idx_d = pos_x;
    end else if (cmd_i.idx_ld_cnt) begin
      idx_d = cnt_x;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_up;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_dn;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rd_val_o    = rd_val_q;
  assign cnt_o       = cnt_q;
  assign st_o        = st_q;

endmodule

`default_nettype wire

// File: rtl/core/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values with append, read, overwrite,
// delete-at-index and insert-at-index, one result beat per input beat.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read memory of DEPTH
// words; a controller FSM sequences every operation through it. Append, read
// and overwrite are latched, then checked and executed, then placed in the
// result register. Delete and insert move elements one at a time through
// the memory port, a read and a write per moved element, and the number of
// moved elements is count-pos-1 for delete and count-pos for insert. A new
// input beat is taken once the previous one has been placed in the result
// register; that register holds its beat until the sink takes it, so the
// next item can already run. Failing items (list full, index out of range)
// report a status and leave the list untouched; unused operation codes
// report ok with the count unchanged. Memory contents after reset are
// undefined, but only written entries are ever read. Positions are 6 bits,
// so only the first 64 entries are addressable by index, and the reported
// count is the low 7 bits of the internal count.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input beat
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [ild_pkg::IN_W-1:0]  s_axis_tdata,  // [2:0] operation, [8:3] position,
                                                   // [40:9] value, [47:41] zero
  // result beat
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [ild_pkg::OUT_W-1:0] m_axis_tdata   // [31:0] read_value,
                                                   // [38:32] element_count,
                                                   // [40:39] status, [47:41] zero
);
  import ild_pkg::*;

  ild_cmd_t cmd;
  ild_sts_t sts;

  logic signed [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0]        cnt;
  logic [ST_W-1:0]         st;

  ild_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ild_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tdata[2:0]),
    .pos_i       (s_axis_tdata[8:3]),
    .val_i       (s_axis_tdata[40:9]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rd_val_o    (rd_val),
    .cnt_o       (cnt),
    .st_o        (st)
  );

  assign m_axis_tdata = {7'd0, st, cnt, rd_val};

endmodule

`default_nettype wire
